// ----- design/off_by_one_age_misclassification_defines.svh -----
// Assertion macros shared by the checker of the ageing-error smoother.
`ifndef OFF_BY_ONE_AGE_MISCLASSIFICATION_DEFINES_SVH
`define OFF_BY_ONE_AGE_MISCLASSIFICATION_DEFINES_SVH

// Same-cycle implication, off during reset.
`define OBOM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("obom check failed");

// Next-cycle implication, off during reset.
`define OBOM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("obom check failed");

// What must hold in the cycle after a reset edge.
`define OBOM_ASSERT_RST(lbl, cons) \
  lbl: assert property (@(posedge clk) rst |=> (cons)) \
    else $error("obom reset check failed");

`endif

// ----- design/obom_pkg.sv -----
// Types and constants shared by the ageing-error smoother.
package obom_pkg;

  localparam int MAX_CLASSES_DEF = 256;

  localparam int VAL_W      = 32;
  localparam int RATE_W     = 16;
  localparam int DIAG_W     = RATE_W + 1;
  localparam int EXACT_W    = 8;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  localparam logic [DIAG_W-1:0] ONE_Q16 = DIAG_W'(65536);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DOWN_RATE = 8'd0,
    REG_UP_RATE   = 8'd1,
    REG_EXACT     = 8'd2,
    REG_PLUS      = 8'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [RATE_W-1:0]  down_rate;
    logic [RATE_W-1:0]  up_rate;
    logic [EXACT_W-1:0] exact_classes;
    logic               plus_group;
  } cfg_t;

  // One accepted element with the window as it stood before it.
  typedef struct packed {
    logic             valid;
    logic [VAL_W-1:0] value;
    logic             last;
    logic [VAL_W-1:0] held;
    logic [VAL_W-1:0] older;
  } stage_t;

endpackage

// ----- design/obom_ifs.sv -----
// Channel interfaces: configuration writes, input elements, results.
interface obom_cfg_if;
  import obom_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

interface obom_in_if;
  import obom_pkg::*;
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] value;
  logic             last;
  modport source (output valid, value, last, input ready);
  modport sink (input valid, value, last, output ready);
endinterface

interface obom_out_if;
  import obom_pkg::*;
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] result;
  logic             final_res;
  modport source (output valid, result, final_res, input ready);
  modport sink (input valid, result, final_res, output ready);
endinterface

// ----- design/off_by_one_age_misclassification.sv -----
// Top level: off-by-one ageing-error smoother over a streamed at-age vector.
//
//   channel   dir  beat carries                      accepted when
//   cfg       in   index (8b), data (16b)            cfg.valid & cfg.ready
//   samples   in   value (Q24.8), last               samples.valid & samples.ready
//   results   out  result (Q24.8, sat), final_res    results.valid & results.ready
//
// One element per cycle while samples.ready is high. An element enters the input
// register, the result for the class before it is formed by three 32x17 products
// and a saturating sum, and is then registered in the result register.
// The element marked last of a vector longer than one class gives two results,
// so it holds the input register until both are in the result register; an
// element at class 0 that is not last gives none, and any other gives one.
// Reset (rst, synchronous) clears the window, the position and the
// registers to down 0, up 0, exact 0, plus group 1; no clearing pass.
// cfg is always ready. A waiting result holds the input register once it
// carries an element that owes a result, and that drops samples.ready.
module off_by_one_age_misclassification #(
  parameter int MAX_CLASSES = obom_pkg::MAX_CLASSES_DEF
) (
  input logic        clk,
  input logic        rst,
  obom_cfg_if.sink   cfg,
  obom_in_if.sink    samples,
  obom_out_if.source results
);
  import obom_pkg::*;

  localparam int POS_W = $clog2(MAX_CLASSES);

  cfg_t             regs;
  stage_t           stg;
  logic [POS_W-1:0] stg_pos;
  logic             advance;

  // Register file: rates, exact-class count, plus-group flag.
  obom_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // Input register plus the two previous elements and the class index.
  obom_window #(
    .MAX_CLASSES (MAX_CLASSES)
  ) u_window (
    .clk     (clk),
    .rst     (rst),
    .samples (samples),
    .advance (advance),
    .stg     (stg),
    .stg_pos (stg_pos)
  );

  // Row weights and products; advance frees the input register once every
  // result of the element is in the result register.
  obom_calc #(
    .MAX_CLASSES (MAX_CLASSES)
  ) u_calc (
    .clk     (clk),
    .rst     (rst),
    .regs    (regs),
    .stg     (stg),
    .stg_pos (stg_pos),
    .advance (advance),
    .results (results)
  );

endmodule

// ----- design/obom_cfg.sv -----
// Configuration register file of the ageing-error smoother.
module obom_cfg (
  input  logic          clk,
  input  logic          rst,
  obom_cfg_if.sink      cfg,
  output obom_pkg::cfg_t regs
);
  import obom_pkg::*;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.down_rate     <= '0;
      regs.up_rate       <= '0;
      regs.exact_classes <= '0;
      regs.plus_group    <= 1'b1;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg_reg_t'(cfg.index))
        REG_DOWN_RATE: regs.down_rate     <= cfg.data;
        REG_UP_RATE:   regs.up_rate       <= cfg.data;
        REG_EXACT:     regs.exact_classes <= cfg.data[EXACT_W-1:0];
        REG_PLUS:      regs.plus_group    <= cfg.data[0];
        default: ;
      endcase
    end
  end

endmodule

// ----- design/obom_window.sv -----
// Input register and two-element sliding window with class position.
module obom_window #(
  parameter  int MAX_CLASSES = obom_pkg::MAX_CLASSES_DEF,
  localparam int POS_W       = $clog2(MAX_CLASSES)
) (
  input  logic             clk,
  input  logic             rst,
  obom_in_if.sink          samples,
  input  logic             advance,
  output obom_pkg::stage_t stg,
  output logic [POS_W-1:0] stg_pos
);
  import obom_pkg::*;

  localparam logic [POS_W-1:0] POS_TOP = POS_W'(MAX_CLASSES - 1);

  logic [VAL_W-1:0] older_value;
  logic [VAL_W-1:0] held_value;
  logic [POS_W-1:0] position;
  logic             take;

  assign samples.ready = !stg.valid || advance;
  assign take          = samples.valid && samples.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg.valid   <= 1'b0;
      older_value <= '0;
      held_value  <= '0;
      position    <= '0;
    end else if (take) begin
      stg.valid <= 1'b1;
      stg.value <= samples.value;
      stg.last  <= samples.last;
      stg.held  <= held_value;
      stg.older <= older_value;
      stg_pos   <= position;
      if (samples.last) begin
        older_value <= '0;
        held_value  <= '0;
        position    <= '0;
      end else begin
        older_value <= held_value;
        held_value  <= samples.value;
        if (position != POS_TOP) begin
          position <= position + POS_W'(1);
        end
      end
    end else if (advance) begin
      stg.valid <= 1'b0;
    end
  end

endmodule

// ----- design/obom_calc.sv -----
// Row weights, three products, saturating sum and the result register.
module obom_calc #(
  parameter  int MAX_CLASSES = obom_pkg::MAX_CLASSES_DEF,
  localparam int POS_W       = $clog2(MAX_CLASSES)
) (
  input  logic             clk,
  input  logic             rst,
  input  obom_pkg::cfg_t   regs,
  input  obom_pkg::stage_t stg,
  input  logic [POS_W-1:0] stg_pos,
  output logic             advance,
  obom_out_if.source       results
);
  import obom_pkg::*;

  localparam int CMP_W  = (POS_W > EXACT_W) ? POS_W : EXACT_W;
  localparam int PROD_W = VAL_W + DIAG_W;
  localparam int SUM_W  = VAL_W + 2;

  function automatic logic is_exact(input logic [POS_W-1:0] i,
                                    input logic [EXACT_W-1:0] k);
    return CMP_W'(i) < CMP_W'(k);
  endfunction

  // Diagonal share, clamped at zero; a whole one on exact rows.
  function automatic logic [DIAG_W-1:0] diag_share(input logic ex,
                                                   input logic use_down,
                                                   input logic use_up,
                                                   input cfg_t c);
    logic [DIAG_W-1:0] lost;
    lost = (use_down ? DIAG_W'(c.down_rate) : '0) + (use_up ? DIAG_W'(c.up_rate) : '0);
    if (ex) return ONE_Q16;
    return (lost >= ONE_Q16) ? '0 : ONE_Q16 - lost;
  endfunction

  logic              phase;
  logic [POS_W-1:0]  j_m1, j_m2;
  logic              j_nz, j_ge2, ex_j, ex_m1, ex_m2;
  logic              head_first, has_res, o_free, emit, last_of_item;
  logic [VAL_W-1:0]  a, b, c;
  logic [DIAG_W-1:0] ra, rb, rc;
  logic [PROD_W-1:0] prod_a, prod_b, prod_c;
  logic [SUM_W-1:0]  sum;
  logic [VAL_W-1:0]  sat_sum;

  assign j_nz  = stg_pos != '0;
  assign j_ge2 = stg_pos > POS_W'(1);
  assign j_m1  = stg_pos - POS_W'(1);
  assign j_m2  = stg_pos - POS_W'(2);
  assign ex_j  = is_exact(stg_pos, regs.exact_classes);
  assign ex_m1 = is_exact(j_m1, regs.exact_classes);
  assign ex_m2 = is_exact(j_m2, regs.exact_classes);

  // First result closes class j-1; second (last element only) closes class j.
  assign head_first = j_nz && !phase;

  always_comb begin
    if (head_first) begin
      a  = stg.older;
      ra = (j_ge2 && !ex_m2) ? DIAG_W'(regs.up_rate) : '0;
      b  = stg.held;
      rb = diag_share(ex_m1, j_m1 != '0, 1'b1, regs);
      c  = stg.value;
      rc = ex_j ? '0 : DIAG_W'(regs.down_rate);
    end else begin
      a  = '0;
      ra = '0;
      b  = stg.held;
      rb = (j_nz && !ex_m1) ? DIAG_W'(regs.up_rate) : '0;
      c  = stg.value;
      rc = diag_share(ex_j, j_nz, !regs.plus_group, regs);
    end
  end

  assign prod_a = PROD_W'(a) * PROD_W'(ra);
  assign prod_b = PROD_W'(b) * PROD_W'(rb);
  assign prod_c = PROD_W'(c) * PROD_W'(rc);

  assign sum = SUM_W'(prod_a[VAL_W+RATE_W-1:RATE_W])
             + SUM_W'(prod_b[VAL_W+RATE_W-1:RATE_W])
             + SUM_W'(prod_c[VAL_W+RATE_W-1:RATE_W]);
  assign sat_sum = (sum[SUM_W-1:VAL_W] != '0) ? '1 : sum[VAL_W-1:0];

  assign has_res      = j_nz || stg.last;
  assign o_free       = !results.valid || results.ready;
  assign emit         = stg.valid && has_res && o_free;
  assign last_of_item = !(head_first && stg.last);
  assign advance      = stg.valid && (!has_res || (o_free && last_of_item));

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
      phase         <= 1'b0;
    end else begin
      if (emit) begin
        results.valid     <= 1'b1;
        results.result    <= sat_sum;
        results.final_res <= !head_first;
      end else if (results.ready) begin
        results.valid <= 1'b0;
      end
      if (advance) begin
        phase <= 1'b0;
      end else if (emit) begin
        phase <= 1'b1;
      end
    end
  end

endmodule

// ----- design/obom_check.sv -----
// Port-level checker for the ageing-error smoother, bound to the top level.
`include "off_by_one_age_misclassification_defines.svh"

module obom_check (
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [obom_pkg::VAL_W-1:0] out_result,
  input logic                    out_final
);
  import obom_pkg::*;

  // Result register is empty after reset.
  `OBOM_ASSERT_RST(a_rst_empty, !out_valid)

  // A held result beat keeps its payload.
  `OBOM_ASSERT_NXT(a_out_hold, out_valid && !out_ready,
                   out_valid && $stable(out_result) && $stable(out_final))

  // From an empty result register, a result rises only after an element was accepted and passed the input register.
  `OBOM_ASSERT_IMP(a_rise_src, $rose(out_valid), $past(in_valid && in_ready, 2))

  // Input stalls only with a result about to be or already waiting.
  `OBOM_ASSERT_NXT(a_stall_out, !in_ready, out_valid)

endmodule

bind off_by_one_age_misclassification obom_check u_obom_check (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (samples.valid),
  .in_ready   (samples.ready),
  .out_valid  (results.valid),
  .out_ready  (results.ready),
  .out_result (results.result),
  .out_final  (results.final_res)
);
